@@ design/b2r_pkg.sv @@
// package for the bgr888 to rgb565 hud overlay block
// register indexes, overlay geometry, colors and the shared config struct
// no dependencies
package b2r_pkg;

   localparam int unsigned DEFAULT_COORD_BITS = 12;

   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_ACTIVE_WIDTH      = 3'd0,
      REG_ACTIVE_HEIGHT     = 3'd1,
      REG_CROSS_HALF_LENGTH = 3'd2,
      REG_HUD_LEFT          = 3'd3,
      REG_HUD_TOP           = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [12:0] active_width;
      logic [12:0] active_height;
      logic [7:0]  cross_half_length;
      logic [11:0] hud_left;
      logic [11:0] hud_top;
   } overlay_cfg_type;

   typedef struct packed {
      logic [15:0] pixel;
      logic        line_end;
      logic        frame_end;
   } pixel_meta_type;

   localparam logic [12:0] RESET_ACTIVE_WIDTH      = 13'd1920;
   localparam logic [12:0] RESET_ACTIVE_HEIGHT     = 13'd1080;
   localparam logic [7:0]  RESET_CROSS_HALF_LENGTH = 8'd20;
   localparam logic [11:0] RESET_HUD_LEFT          = 12'd30;
   localparam logic [11:0] RESET_HUD_TOP           = 12'd30;

   localparam int unsigned HUD_W          = 200;
   localparam int unsigned HUD_H          = 100;
   localparam int unsigned STRIPE_L_LEFT  = 10;
   localparam int unsigned STRIPE_L_RIGHT = 60;
   localparam int unsigned STRIPE_W_LEFT  = 140;
   localparam int unsigned STRIPE_W_RIGHT = 190;
   localparam int unsigned RED_TOP        = 10;
   localparam int unsigned RED_BOTTOM     = 30;
   localparam int unsigned GREEN_TOP      = 35;
   localparam int unsigned GREEN_BOTTOM   = 55;
   localparam int unsigned BLUE_TOP       = 60;
   localparam int unsigned BLUE_BOTTOM    = 80;

   localparam logic [15:0] COLOR_CROSS = 16'hFFE0;
   localparam logic [15:0] COLOR_BLACK = 16'h0000;
   localparam logic [15:0] COLOR_RED   = 16'hF800;
   localparam logic [15:0] COLOR_GREEN = 16'h07E0;
   localparam logic [15:0] COLOR_BLUE  = 16'h001F;
   localparam logic [15:0] COLOR_WHITE = 16'hFFFF;

   // zero counts as one, anything above 2^cb saturates
   function automatic logic [16:0] eff_size(input logic [12:0] v, input int unsigned cb);
      logic [17:0] lim;
      logic [17:0] ext;
      lim = 18'(1) << cb;
      ext = {5'b0, v};
      if (v == 13'd0) begin
         return 17'd1;
      end else if (ext > lim) begin
         return lim[16:0];
      end else begin
         return ext[16:0];
      end
   endfunction

endpackage

@@ design/b2r_front.sv @@
// front end: accepts pixels, tracks column and row, cuts to rgb565
// and marks line and frame ends; depends on b2r_pkg
module b2r_front #(
   parameter int unsigned COORD_BITS = b2r_pkg::DEFAULT_COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  b2r_pkg::overlay_cfg_type     cfg,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_blue,
   input  logic [7:0]                   req_green,
   input  logic [7:0]                   req_red,
   input  logic                         req_frame_start,
   input  logic                         q_full,
   output logic                         q_push,
   output b2r_pkg::pixel_meta_type      q_meta,
   output logic [COORD_BITS-1:0]        q_col,
   output logic [COORD_BITS-1:0]        q_row
);
   import b2r_pkg::*;

   localparam int unsigned SB = COORD_BITS + 1;

   logic [COORD_BITS-1:0] col_ff, col_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic [COORD_BITS-1:0] col_cur, row_cur;
   logic [SB-1:0]         w_eff, h_eff;
   logic                  le, fe;

   assign w_eff = SB'(eff_size(cfg.active_width, COORD_BITS));
   assign h_eff = SB'(eff_size(cfg.active_height, COORD_BITS));

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;

   always_comb begin
      col_cur = req_frame_start ? '0 : col_ff;
      row_cur = req_frame_start ? '0 : row_ff;
      le = SB'(col_cur) >= (w_eff - SB'(1));
      fe = le && (SB'(row_cur) >= (h_eff - SB'(1)));
      if (le) begin
         col_in = '0;
         row_in = fe ? '0 : row_cur + COORD_BITS'(1);
      end else begin
         col_in = col_cur + COORD_BITS'(1);
         row_in = row_cur;
      end
   end

   assign q_meta.pixel     = {req_red[7:3], req_green[7:2], req_blue[7:3]};
   assign q_meta.line_end  = le;
   assign q_meta.frame_end = fe;
   assign q_col = col_cur;
   assign q_row = row_cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (q_push) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

@@ design/b2r_fifo.sv @@
// two-entry queue between front and back ends
// no package dependencies
module b2r_fifo #(
   parameter int unsigned DW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [DW-1:0] push_data,
   input  logic          pop,
   output logic [DW-1:0] head_data,
   output logic          empty,
   output logic          full,
   output logic [1:0]    count
);
   logic [DW-1:0] mem_ff [2];
   logic          wr_ptr_ff, rd_ptr_ff;
   logic [1:0]    count_ff, count_in;

   assign head_data = mem_ff[rd_ptr_ff];
   assign empty     = (count_ff == 2'd0);
   assign full      = (count_ff == 2'd2);
   assign count     = count_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

endmodule

@@ design/b2r_back.sv @@
// back end: draws crosshair, hud box and test stripes over the queued pixel
// and holds the result register; depends on b2r_pkg
module b2r_back #(
   parameter int unsigned COORD_BITS = b2r_pkg::DEFAULT_COORD_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  b2r_pkg::overlay_cfg_type cfg,
   input  logic                     q_empty,
   input  b2r_pkg::pixel_meta_type  q_meta,
   input  logic [COORD_BITS-1:0]    q_col,
   input  logic [COORD_BITS-1:0]    q_row,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [15:0]              rsp_pixel_out,
   output logic                     rsp_line_end,
   output logic                     rsp_frame_end
);
   import b2r_pkg::*;

   localparam int unsigned SB = COORD_BITS + 1;
   localparam int unsigned XB = ((COORD_BITS > 12) ? COORD_BITS : 12) + 2;

   logic           rsp_valid_ff, rsp_valid_in;
   pixel_meta_type rsp_ff;
   logic [15:0]    pix;
   logic [SB-1:0]  w_eff, h_eff;
   logic [XB-1:0]  colx, rowx, cx, cy, len, lo_h, lo_v, hx, hy;
   logic           cols_l, cols_w;

   assign w_eff = SB'(eff_size(cfg.active_width, COORD_BITS));
   assign h_eff = SB'(eff_size(cfg.active_height, COORD_BITS));

   assign colx = XB'(q_col);
   assign rowx = XB'(q_row);
   assign cx   = XB'(w_eff >> 1);
   assign cy   = XB'(h_eff >> 1);
   assign len  = XB'(cfg.cross_half_length);
   assign lo_h = (cx >= len) ? cx - len : '0;
   assign lo_v = (cy >= len) ? cy - len : '0;
   assign hx   = XB'(cfg.hud_left);
   assign hy   = XB'(cfg.hud_top);

   assign cols_l = (colx >= hx + XB'(STRIPE_L_LEFT)) && (colx < hx + XB'(STRIPE_L_RIGHT));
   assign cols_w = (colx >= hx + XB'(STRIPE_W_LEFT)) && (colx < hx + XB'(STRIPE_W_RIGHT));

   // later drawings override earlier ones
   always_comb begin
      pix = q_meta.pixel;
      if (rowx == cy && colx >= lo_h && colx <= cx + len) begin
         pix = COLOR_CROSS;
      end
      if (colx == cx && rowx >= lo_v && rowx <= cy + len) begin
         pix = COLOR_CROSS;
      end
      if (colx >= hx && colx < hx + XB'(HUD_W) && rowx >= hy && rowx < hy + XB'(HUD_H)) begin
         pix = COLOR_BLACK;
      end
      if (cols_l) begin
         if (rowx >= hy + XB'(RED_TOP) && rowx < hy + XB'(RED_BOTTOM)) begin
            pix = COLOR_RED;
         end
         if (rowx >= hy + XB'(GREEN_TOP) && rowx < hy + XB'(GREEN_BOTTOM)) begin
            pix = COLOR_GREEN;
         end
         if (rowx >= hy + XB'(BLUE_TOP) && rowx < hy + XB'(BLUE_BOTTOM)) begin
            pix = COLOR_BLUE;
         end
      end
      if (cols_w && rowx >= hy + XB'(RED_TOP) && rowx < hy + XB'(BLUE_BOTTOM)) begin
         pix = COLOR_WHITE;
      end
   end

   assign q_pop = !q_empty && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff.pixel     <= pix;
         rsp_ff.line_end  <= q_meta.line_end;
         rsp_ff.frame_end <= q_meta.frame_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_ff.pixel;
   assign rsp_line_end  = rsp_ff.line_end;
   assign rsp_frame_end = rsp_ff.frame_end;

endmodule

@@ design/bgr_to_rgb565_hud_overlay.sv @@
// top level of the bgr888 to rgb565 converter with hud overlay
// holds the config registers and joins front end, queue and back end
// depends on b2r_pkg, b2r_front, b2r_fifo, b2r_back
//
// usage:
//   req_*  one bgr888 pixel per item in raster order; req_frame_start marks
//          the first pixel of a frame and moves the position to the origin
//   rsp_*  one rgb565 pixel per item with line and frame end marks
//   csr_*  register writes (index, data), always ready, only while idle
// path: an accepted pixel is written into the queue, then the back end registers it in the output register
// throughput: one pixel per cycle while rsp_ready holds; the front end takes a pixel whenever the
//   two-entry queue has room, the back end drains it into the output register
// reset: position goes to (0,0), the queue empties, registers take their
//   default mode (1920x1080, arm 20, hud at 30,30)
// receiver stall: the output register holds, the queue fills, and req_ready
//   drops once both queue entries are taken, one item later with a steady input
module bgr_to_rgb565_hud_overlay #(
   parameter int unsigned COORD_BITS = b2r_pkg::DEFAULT_COORD_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_blue,
   input  logic [7:0]                         req_green,
   input  logic [7:0]                         req_red,
   input  logic                               req_frame_start,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [15:0]                        rsp_pixel_out,
   output logic                               rsp_line_end,
   output logic                               rsp_frame_end,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [b2r_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [b2r_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import b2r_pkg::*;

   localparam int unsigned DW = $bits(pixel_meta_type) + 2 * COORD_BITS;

   overlay_cfg_type       cfg_ff, cfg_in;
   pixel_meta_type        f_meta, b_meta;
   logic [COORD_BITS-1:0] f_col, f_row, b_col, b_row;
   logic                  q_push, q_pop, q_empty, q_full;
   logic [1:0]            q_count;
   logic [DW-1:0]         q_head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_ACTIVE_WIDTH:      cfg_in.active_width      = csr_wdata[12:0];
            REG_ACTIVE_HEIGHT:     cfg_in.active_height     = csr_wdata[12:0];
            REG_CROSS_HALF_LENGTH: cfg_in.cross_half_length = csr_wdata[7:0];
            REG_HUD_LEFT:          cfg_in.hud_left          = csr_wdata[11:0];
            REG_HUD_TOP:           cfg_in.hud_top           = csr_wdata[11:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_width      <= RESET_ACTIVE_WIDTH;
         cfg_ff.active_height     <= RESET_ACTIVE_HEIGHT;
         cfg_ff.cross_half_length <= RESET_CROSS_HALF_LENGTH;
         cfg_ff.hud_left          <= RESET_HUD_LEFT;
         cfg_ff.hud_top           <= RESET_HUD_TOP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   b2r_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_blue        (req_blue),
      .req_green       (req_green),
      .req_red         (req_red),
      .req_frame_start (req_frame_start),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_meta          (f_meta),
      .q_col           (f_col),
      .q_row           (f_row)
   );

   b2r_fifo #(
      .DW(DW)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_meta, f_col, f_row}),
      .pop       (q_pop),
      .head_data (q_head),
      .empty     (q_empty),
      .full      (q_full),
      .count     (q_count)
   );

   assign {b_meta, b_col, b_row} = q_head;

   b2r_back #(
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .q_empty       (q_empty),
      .q_meta        (b_meta),
      .q_col         (b_col),
      .q_row         (b_row),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_line_end  (rsp_line_end),
      .rsp_frame_end (rsp_frame_end)
   );

`ifndef SYNTHESIS
   a_frame_end_on_line_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_frame_end || rsp_line_end))
      else $error("frame end without line end");

   a_accepted_item_queued: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (q_count != 2'd0))
      else $error("accepted item missing from queue");

   a_ready_tracks_queue: assert property (@(posedge clock) disable iff (reset)
      req_ready == (q_count != 2'd2))
      else $error("req_ready does not follow queue fill");

   a_rsp_drop_only_on_take: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(rsp_ready))
      else $error("result dropped without being taken");
`endif

endmodule

@@ bench/tb_b2r_scoreboard_pkg.sv @@
// scoreboard for the bgr888 to rgb565 hud overlay bench: pixel predictor,
// its own copy of the registers and position, and the queue of expected pixels
// depends on b2r_pkg
package tb_b2r_scoreboard_pkg;
   import b2r_pkg::*;

   localparam int unsigned POS_BITS   = 12;
   localparam int unsigned SIZE_LIMIT = 1 << POS_BITS;
   localparam int unsigned BOX_W      = 200;
   localparam int unsigned BOX_H      = 100;

   localparam logic [15:0] PIX_CROSS = 16'hFFE0;
   localparam logic [15:0] PIX_BLACK = 16'h0000;
   localparam logic [15:0] PIX_RED   = 16'hF800;
   localparam logic [15:0] PIX_GREEN = 16'h07E0;
   localparam logic [15:0] PIX_BLUE  = 16'h001F;
   localparam logic [15:0] PIX_WHITE = 16'hFFFF;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LAST  = 3'd7;

   class pixel_scoreboard;
      overlay_cfg_type     cfg;
      logic [POS_BITS-1:0] col_pos;
      logic [POS_BITS-1:0] row_pos;
      pixel_meta_type      expected_q[$];
      int unsigned         fails;
      int unsigned         checked;

      function new();
         cfg.active_width      = 13'd1920;
         cfg.active_height     = 13'd1080;
         cfg.cross_half_length = 8'd20;
         cfg.hud_left          = 12'd30;
         cfg.hud_top           = 12'd30;
         col_pos = '0;
         row_pos = '0;
         fails   = 0;
         checked = 0;
      endfunction

      function void apply_write(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            REG_ACTIVE_WIDTH:      cfg.active_width      = data[12:0];
            REG_ACTIVE_HEIGHT:     cfg.active_height     = data[12:0];
            REG_CROSS_HALF_LENGTH: cfg.cross_half_length = data[7:0];
            REG_HUD_LEFT:          cfg.hud_left          = data[11:0];
            REG_HUD_TOP:           cfg.hud_top           = data[11:0];
            default: ;
         endcase
      endfunction

      function int unsigned clamp_size(logic [12:0] v);
         if (v == 13'd0) return 1;
         if (v > SIZE_LIMIT) return SIZE_LIMIT;
         return v;
      endfunction

      function bit span(int unsigned v, int unsigned lo, int unsigned hi);
         return v >= lo && v < hi;
      endfunction

      function pixel_meta_type predict(logic [7:0] blue, logic [7:0] green, logic [7:0] red,
                                       logic fs);
         int unsigned    w, h, c, r, cx, cy, len, lo, hx, hy;
         logic [15:0]    pix;
         logic           le, fe;
         pixel_meta_type res;
         w = clamp_size(cfg.active_width);
         h = clamp_size(cfg.active_height);
         if (fs) begin
            col_pos = '0;
            row_pos = '0;
         end
         c = col_pos;
         r = row_pos;
         pix = {red[7:3], green[7:2], blue[7:3]};

         // crosshair, arms clamped at the top and left edges
         cx  = w / 2;
         cy  = h / 2;
         len = cfg.cross_half_length;
         lo  = (cx >= len) ? cx - len : 0;
         if (r == cy && c >= lo && c <= cx + len) pix = PIX_CROSS;
         lo  = (cy >= len) ? cy - len : 0;
         if (c == cx && r >= lo && r <= cy + len) pix = PIX_CROSS;

         // hud box, then the stripes inside it
         hx = cfg.hud_left;
         hy = cfg.hud_top;
         if (span(c, hx, hx + BOX_W) && span(r, hy, hy + BOX_H)) pix = PIX_BLACK;
         if (span(c, hx + 10, hx + 60)) begin
            if (span(r, hy + 10, hy + 30)) pix = PIX_RED;
            if (span(r, hy + 35, hy + 55)) pix = PIX_GREEN;
            if (span(r, hy + 60, hy + 80)) pix = PIX_BLUE;
         end
         if (span(c, hx + 140, hx + 190) && span(r, hy + 10, hy + 80)) pix = PIX_WHITE;

         le = (c >= w - 1);
         fe = le && (r >= h - 1);
         if (le) begin
            col_pos = '0;
            row_pos = fe ? '0 : POS_BITS'(r + 1);
         end else begin
            col_pos = POS_BITS'(c + 1);
         end
         res.pixel     = pix;
         res.line_end  = le;
         res.frame_end = fe;
         return res;
      endfunction

      function void note_pixel(logic [7:0] blue, logic [7:0] green, logic [7:0] red, logic fs);
         expected_q.push_back(predict(blue, green, red, fs));
      endfunction

      function void check_pixel(logic [15:0] pix, logic le, logic fe);
         pixel_meta_type exp_item;
         checked++;
         if (expected_q.size() == 0) begin
            $error("pixel_out: no item expected, actual %h", pix);
            fails++;
            return;
         end
         exp_item = expected_q.pop_front();
         if (pix !== exp_item.pixel) begin
            $error("pixel_out: expected %h, actual %h", exp_item.pixel, pix);
            fails++;
         end
         if (le !== exp_item.line_end) begin
            $error("line_end: expected %b, actual %b", exp_item.line_end, le);
            fails++;
         end
         if (fe !== exp_item.frame_end) begin
            $error("frame_end: expected %b, actual %b", exp_item.frame_end, fe);
            fails++;
         end
      endfunction
   endclass

endpackage

@@ bench/tb_bgr_to_rgb565_hud_overlay.sv @@
// top of the bench for bgr_to_rgb565_hud_overlay: drives pixels and register
// writes with random gaps and stalls, checks every pixel against the scoreboard
// depends on b2r_pkg, tb_b2r_scoreboard_pkg and the design
module tb_bgr_to_rgb565_hud_overlay;
   timeunit 1ns;
   timeprecision 1ps;

   import b2r_pkg::*;
   import tb_b2r_scoreboard_pkg::*;

   localparam int unsigned RUN_ITEMS    = 1400;
   localparam int unsigned CALM_ITEMS   = 1200;
   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam int unsigned HOLD_AT      = 700;
   localparam int unsigned HOLD_CYCLES  = 100;
   localparam int unsigned DRAIN_CYCLES = 8;

   logic                      clock;
   logic                      reset           = 1'b1;
   logic                      req_valid       = 1'b0;
   logic [7:0]                req_blue        = '0;
   logic [7:0]                req_green       = '0;
   logic [7:0]                req_red         = '0;
   logic                      req_frame_start = 1'b0;
   logic                      rsp_ready       = 1'b0;
   logic                      csr_valid       = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index       = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata       = '0;
   logic                      req_ready;
   logic                      rsp_valid;
   logic [15:0]               rsp_pixel_out;
   logic                      rsp_line_end;
   logic                      rsp_frame_end;
   logic                      csr_ready;

   pixel_scoreboard sb = new();
   bit              calm         = 1'b0;
   bit              hold_stalled = 1'b0;
   int unsigned     gap_pct      = 0;
   int unsigned     random_sent  = 0;
   int unsigned     cycles       = 0;

   bgr_to_rgb565_hud_overlay uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_blue        (req_blue),
      .req_green       (req_green),
      .req_red         (req_red),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_line_end    (rsp_line_end),
      .rsp_frame_end   (rsp_frame_end),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.apply_write(csr_index, csr_wdata);
         if (req_valid && req_ready) sb.note_pixel(req_blue, req_green, req_red, req_frame_start);
         if (rsp_valid && rsp_ready) sb.check_pixel(rsp_pixel_out, rsp_line_end, rsp_frame_end);
         if (req_valid && !req_ready) hold_stalled = 1'b1;
      end
   end

   // receiver: random stall bursts, a long hold repeated until it backs up the input
   initial begin
      int unsigned stall_pct;
      int unsigned span_left;
      bit          held;
      stall_pct = 0;
      span_left = 0;
      held      = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (span_left == 0) begin
            case ($urandom_range(0, 2))
               0:       stall_pct = 0;
               1:       stall_pct = 10;
               default: stall_pct = 35;
            endcase
            span_left = $urandom_range(20, 120);
         end
         span_left--;
         if (!held && sb.checked >= HOLD_AT && req_valid) begin
            hold_stalled = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = hold_stalled;
         end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic fs);
      req_valid       <= 1'b1;
      req_blue        <= b;
      req_green       <= g;
      req_red         <= r;
      req_frame_start <= fs;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random(int unsigned n, int unsigned fs_pct, bit fs_first);
      logic fs;
      for (int unsigned i = 0; i < n; i++) begin
         if (!calm && $urandom_range(0, 99) < gap_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         fs = (i == 0 && fs_first) || ($urandom_range(0, 99) < fs_pct);
         send_pixel(8'($urandom), 8'($urandom), 8'($urandom), fs);
         random_sent++;
         if (random_sent >= CALM_ITEMS) calm = 1'b1;
      end
   endtask

   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_mode(int unsigned w, int unsigned h, int unsigned len,
                           int unsigned hx, int unsigned hy);
      csr_write(REG_ACTIVE_WIDTH, 16'(w));
      csr_write(REG_ACTIVE_HEIGHT, 16'(h));
      csr_write(REG_CROSS_HALF_LENGTH, 16'(len));
      csr_write(REG_HUD_LEFT, 16'(hx));
      csr_write(REG_HUD_TOP, 16'(hy));
      csr_valid <= 1'b0;
   endtask

   // wait until every pixel is out and the pipeline has drained
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_BITS-1:0] edge_value();
      case ($urandom_range(0, 6))
         0:       return 16'h0000;
         1:       return 16'h0001;
         2:       return 16'h0FFF;
         3:       return 16'h1000;
         4:       return 16'h1001;
         5:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int unsigned w, h, hy, climb, pick;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset mode, byte extremes
      send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_pixel(8'h80, 8'h7F, 8'hAA, 1'b0);
      settle();

      // zero width and height act as one, every pixel ends line and frame
      set_mode(0, 0, 0, 4095, 4095);
      send_pixel(8'h55, 8'h01, 8'hFE, 1'b0);
      send_pixel(8'h12, 8'h34, 8'h56, 1'b1);
      send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
      settle();

      // arms longer than the half size clamp at the top and left edges
      set_mode(4, 4, 255, 4095, 4095);
      for (int i = 0; i < 12; i++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == 0);
      settle();

      // oversized and masked sizes saturate, box at the origin
      set_mode(16'hFFFF, 16'h1001, 16'hFFFF, 0, 0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
      send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      settle();

      // spare register index is ignored
      csr_write(CSR_SPARE_FIRST, 16'hFFFF);
      csr_write(CSR_SPARE_LAST, 16'h0000);
      csr_valid <= 1'b0;
      send_pixel(8'hC3, 8'h3C, 8'h99, 1'b0);
      settle();

      // width shrunk under the column: line end and wrap
      set_mode(32, 8, 2, 4095, 4095);
      for (int i = 0; i < 6; i++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == 0);
      settle();
      csr_write(REG_ACTIVE_WIDTH, 16'd3);
      csr_valid <= 1'b0;
      send_pixel(8'h01, 8'h02, 8'h03, 1'b0);
      send_pixel(8'h04, 8'h05, 8'h06, 1'b0);

      while (random_sent < RUN_ITEMS) begin
         settle();
         case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 8;
            default: gap_pct = 25;
         endcase
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            // small frames around the overlay
            w = $urandom_range(1, 40);
            h = $urandom_range(1, 24);
            set_mode(w, h, $urandom_range(0, 24), $urandom_range(0, w), $urandom_range(0, h / 2));
            send_random($urandom_range(20, 80), 2, 1'b1);
         end else if (pick < 65) begin
            // climb rows one pixel per line, then one wide line through the stripes and up to 10 pixels past it
            hy    = $urandom_range(0, 8);
            climb = $urandom_range(hy + 4, hy + 86);
            set_mode(1, $urandom_range(100, 4096), $urandom_range(0, 255), 0, hy);
            send_random(climb, 0, 1'b1);
            settle();
            w = $urandom_range(60, 230);
            csr_write(REG_ACTIVE_WIDTH, 16'(w));
            csr_write(REG_HUD_LEFT, 16'($urandom_range(0, 40)));
            csr_valid <= 1'b0;
            send_random(w + $urandom_range(0, 10), 0, 1'b0);
         end else if (pick < 85) begin
            // register extremes
            if ($urandom_range(0, 1)) csr_write(REG_ACTIVE_WIDTH, edge_value());
            if ($urandom_range(0, 1)) csr_write(REG_ACTIVE_HEIGHT, edge_value());
            if ($urandom_range(0, 1)) csr_write(REG_CROSS_HALF_LENGTH, edge_value());
            if ($urandom_range(0, 1)) csr_write(REG_HUD_LEFT, edge_value());
            if ($urandom_range(0, 1)) csr_write(REG_HUD_TOP, edge_value());
            csr_valid <= 1'b0;
            send_random($urandom_range(20, 50), 6, 1'b0);
         end else begin
            // writes to spare indexes
            repeat ($urandom_range(1, 3)) begin
               csr_write(CSR_INDEX_BITS'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)),
                         16'($urandom));
            end
            csr_valid <= 1'b0;
            send_random($urandom_range(10, 30), 3, 1'b0);
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.fails == 0 && sb.expected_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/b2r_pkg.sv
design/b2r_front.sv
design/b2r_fifo.sv
design/b2r_back.sv
design/bgr_to_rgb565_hud_overlay.sv
bench/tb_b2r_scoreboard_pkg.sv
bench/tb_bgr_to_rgb565_hud_overlay.sv
